// ===== rtl/hmf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hmf_pkg: shared types and constants of the HTTP message framer
// Phase, mode, role, event and error codes, and the request record that
// travels from the front part to the back part.
// ----------------------------------------------------------------------------
package hmf_pkg;

  localparam int LEN_BITS = 32;

  typedef enum logic [3:0] {
    PH_SKIP     = 4'd0,
    PH_TOK1     = 4'd1,
    PH_TOK2     = 4'd2,
    PH_TOK3     = 4'd3,
    PH_START_LF = 4'd4,
    PH_LINE     = 4'd5,
    PH_KEY      = 4'd6,
    PH_VALUE    = 4'd7,
    PH_VALUE_LF = 4'd8,
    PH_END_LF   = 4'd9,
    PH_BODY     = 4'd10,
    PH_CLINE    = 4'd11,
    PH_CLF      = 4'd12,
    PH_CDATA    = 4'd13,
    PH_CCRLF    = 4'd14,
    PH_TRAILER  = 4'd15
  } phase_e;

  typedef enum logic [1:0] {
    MODE_NONE  = 2'd0,
    MODE_LEN   = 2'd1,
    MODE_CHUNK = 2'd2
  } mode_e;

  localparam logic [1:0] ROLE_HEAD  = 2'd0;
  localparam logic [1:0] ROLE_BODY  = 2'd1;
  localparam logic [1:0] ROLE_FRAME = 2'd2;
  localparam logic [1:0] ROLE_DROP  = 2'd3;

  localparam logic [2:0] EV_NONE     = 3'd0;
  localparam logic [2:0] EV_HEAD     = 3'd1;
  localparam logic [2:0] EV_HEAD_LEN = 3'd2;
  localparam logic [2:0] EV_HEAD_CK  = 3'd3;
  localparam logic [2:0] EV_CSIZE    = 3'd4;
  localparam logic [2:0] EV_CDONE    = 3'd5;
  localparam logic [2:0] EV_MSG_END  = 3'd6;
  localparam logic [2:0] EV_ERROR    = 3'd7;

  localparam logic [3:0] ERR_NONE       = 4'd0;
  localparam logic [3:0] ERR_HEAD_LONG  = 4'd1;
  localparam logic [3:0] ERR_START      = 4'd2;
  localparam logic [3:0] ERR_FIELD      = 4'd3;
  localparam logic [3:0] ERR_BAD_LEN    = 4'd4;
  localparam logic [3:0] ERR_TE_CL      = 4'd5;
  localparam logic [3:0] ERR_DUP_LEN    = 4'd6;
  localparam logic [3:0] ERR_BODY_LONG  = 4'd7;
  localparam logic [3:0] ERR_CHUNK_LINE = 4'd8;
  localparam logic [3:0] ERR_CHUNK_LONG = 4'd9;
  localparam logic [3:0] ERR_NO_CRLF    = 4'd10;
  localparam logic [3:0] ERR_TRAIL_LONG = 4'd11;

  localparam logic CFG_HEAD_LIMIT = 1'b0;
  localparam logic CFG_BODY_LIMIT = 1'b1;

  localparam logic [12:0] HEAD_LIMIT_RESET = 13'd4096;
  localparam logic [31:0] BODY_LIMIT_RESET = 32'd67108864;
  localparam logic [4:0]  CHUNK_LINE_MAX   = 5'd15;
  localparam logic [4:0]  TE_LEN           = 5'd17;
  localparam logic [4:0]  CL_LEN           = 5'd14;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_HT    = 8'h09;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_SEMI  = 8'h3B;

  // front to back request: the byte plus its classification
  typedef struct packed {
    logic [7:0] data;
    logic       hex_ok;
    logic [3:0] hex;
    logic       dig_ok;
    logic [3:0] dig;
    logic       ows;
  } class_t;

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
  endfunction

  function automatic logic [7:0] te_char(input logic [4:0] i);
    logic [7:0] r;
    unique case (i)
      5'd0: r = "t";  5'd1: r = "r";  5'd2: r = "a";  5'd3: r = "n";
      5'd4: r = "s";  5'd5: r = "f";  5'd6: r = "e";  5'd7: r = "r";
      5'd8: r = "-";  5'd9: r = "e";  5'd10: r = "n"; 5'd11: r = "c";
      5'd12: r = "o"; 5'd13: r = "d"; 5'd14: r = "i"; 5'd15: r = "n";
      5'd16: r = "g";
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] cl_char(input logic [4:0] i);
    logic [7:0] r;
    unique case (i)
      5'd0: r = "c";  5'd1: r = "o";  5'd2: r = "n";  5'd3: r = "t";
      5'd4: r = "e";  5'd5: r = "n";  5'd6: r = "t";  5'd7: r = "-";
      5'd8: r = "l";  5'd9: r = "e";  5'd10: r = "n"; 5'd11: r = "g";
      5'd12: r = "t"; 5'd13: r = "h";
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] ck_char(input logic [2:0] i);
    logic [7:0] r;
    unique case (i)
      3'd0: r = "c"; 3'd1: r = "h"; 3'd2: r = "u"; 3'd3: r = "n";
      3'd4: r = "k"; 3'd5: r = "e"; 3'd6: r = "d";
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/http_message_framer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_message_framer_unit: HTTP/1.1 framer, one byte per cycle unless full
// Front stage registers and classifies bytes; back stage parses and queues.
// ----------------------------------------------------------------------------
// Accepts one byte per cycle and returns one result per byte at a sustained
// rate of one per cycle while results are popped, set by the parser state
// update in the back stage. A full output queue holds off the parser and
// raises full. A pushed byte is held in the front register, then parsed and
// written into the output queue, where it can be popped. Errors stay set
// until reset. Limit registers are written through cfg_we_i/cfg_idx_i.
module http_message_framer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte_i,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte_o,
  output logic [1:0]  byte_role_o,
  output logic [2:0]  event_res_o,
  output logic [31:0] length_value_o,
  output logic [3:0]  error_code_o,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_data_i
);
  import hmf_pkg::*;

  logic        req_valid, req_ready;
  class_t      req;
  logic [12:0] head_lim_q;
  logic [31:0] body_lim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_lim_q <= HEAD_LIMIT_RESET;
      body_lim_q <= BODY_LIMIT_RESET;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_HEAD_LIMIT) head_lim_q <= cfg_data_i[12:0];
      else body_lim_q <= cfg_data_i;
    end
  end

  hmf_front u_front (
    .clk_i, .rst_ni, .push_i(push), .data_byte_i, .full,
    .req_valid_o(req_valid), .req_o(req), .req_ready_i(req_ready)
  );

  hmf_back u_back (
    .clk_i, .rst_ni, .req_valid_i(req_valid), .req_i(req), .req_ready_o(req_ready),
    .head_limit_i(head_lim_q), .body_limit_i(body_lim_q), .empty, .pop,
    .out_byte_o, .byte_role_o, .event_res_o, .length_value_o, .error_code_o
  );

endmodule

// ===== rtl/hmf_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hmf_front: byte intake and classification
// Registers each byte with its hex and digit values and its blank flag.
// ----------------------------------------------------------------------------
module hmf_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  logic [7:0]      data_byte_i,
  output logic            full,
  output logic            req_valid_o,
  output hmf_pkg::class_t req_o,
  input  logic            req_ready_i
);
  import hmf_pkg::*;

  logic            valid_q;
  class_t          req_q;
  class_t          cls;
  logic [7:0]      lc;

  assign lc = to_lower(data_byte_i);

  always_comb begin
    cls        = '0;
    cls.data   = data_byte_i;
    cls.ows    = (data_byte_i == CH_SP) || (data_byte_i == CH_HT);
    cls.dig_ok = (data_byte_i >= "0") && (data_byte_i <= "9");
    cls.dig    = data_byte_i[3:0];
    if (cls.dig_ok) begin
      cls.hex_ok = 1'b1;
      cls.hex    = data_byte_i[3:0];
    end else if (lc >= "a" && lc <= "f") begin
      cls.hex_ok = 1'b1;
      cls.hex    = 4'(lc - 8'h57);
    end
  end

  assign full        = valid_q && !req_ready_i;
  assign req_valid_o = valid_q;
  assign req_o       = req_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!full) begin
      valid_q <= push_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!full && push_i) begin
      req_q <= cls;
    end
  end

endmodule

// ===== rtl/hmf_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hmf_back: parser state machine and result queue
// Advances the message state by one byte a cycle, when the queue has room,
// and places each result in a two-entry output queue.
// ----------------------------------------------------------------------------
module hmf_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            req_valid_i,
  input  hmf_pkg::class_t req_i,
  output logic            req_ready_o,
  input  logic [12:0]     head_limit_i,
  input  logic [31:0]     body_limit_i,
  output logic            empty,
  input  logic            pop,
  output logic [7:0]      out_byte_o,
  output logic [1:0]      byte_role_o,
  output logic [2:0]      event_res_o,
  output logic [31:0]     length_value_o,
  output logic [3:0]      error_code_o
);
  import hmf_pkg::*;

  localparam int AW = LEN_BITS + 4;

  phase_e              phase_q, phase_d;
  mode_e               mode_q, mode_d;
  logic [12:0]         hcnt_q, hcnt_d;
  logic [23:0]         last_q, last_d;
  logic [4:0]          kpos_q, kpos_d;
  logic [1:0]          kflg_q, kflg_d;
  logic [4:0]          tok_q, tok_d;
  logic [LEN_BITS-1:0] acc_q, acc_d;
  logic [LEN_BITS-1:0] slen_q, slen_d;
  logic [LEN_BITS-1:0] rem_q, rem_d;
  logic [4:0]          lcnt_q, lcnt_d;
  logic [3:0]          serr_q, serr_d;

  logic [7:0]  b;
  logic [7:0]  lc;
  logic [1:0]  role;
  logic [2:0]  ev;
  logic [3:0]  err;
  logic [LEN_BITS-1:0] len;
  logic [AW-1:0] dec_ext, hex_ext;
  logic        fire;
  logic        cr, lf;

  // output queue
  logic [1:0]  cnt_q;
  logic        rd_q, wr_q;
  logic [44:0] mem_q [2];
  logic [44:0] wdata;

  assign req_ready_o = (cnt_q != 2'd2);
  assign fire        = req_valid_i && req_ready_o;
  assign b           = req_i.data;
  assign lc          = to_lower(b);
  assign cr          = (b == CH_CR);
  assign lf          = (b == CH_LF);
  assign dec_ext     = {4'd0, acc_q} * AW'(10) + AW'(req_i.dig);
  assign hex_ext     = {acc_q, 4'd0} + AW'(req_i.hex);

  function automatic logic [31:0] clip(input logic [LEN_BITS-1:0] v);
    return 32'(v);
  endfunction

  always_comb begin
    logic [3:0] s;
    logic       f;
    logic [1:0] nf;
    phase_d = phase_q; mode_d = mode_q; hcnt_d = hcnt_q; last_d = last_q;
    kpos_d = kpos_q; kflg_d = kflg_q; tok_d = tok_q; acc_d = acc_q;
    slen_d = slen_q; rem_d = rem_q; lcnt_d = lcnt_q; serr_d = serr_q;
    role = ROLE_HEAD; ev = EV_NONE; err = ERR_NONE; len = '0;
    s = 4'd0; f = 1'b0; nf = 2'd0;

    if (serr_q != ERR_NONE) begin
      role = ROLE_DROP;
    end else begin
      if (phase_q <= PH_END_LF) begin
        if (hcnt_q >= head_limit_i) err = ERR_HEAD_LONG;
        else hcnt_d = hcnt_q + 13'd1;
      end
      if (err == ERR_NONE) begin
        unique case (phase_q)
          PH_SKIP: begin
            if (!(req_i.ows || cr || lf)) phase_d = PH_TOK1;
          end
          PH_TOK1: begin
            if (b == CH_SP) begin
              phase_d = PH_TOK2; lcnt_d = '0;
            end else if (cr || lf) err = ERR_START;
          end
          PH_TOK2: begin
            if (b == CH_SP) begin
              if (lcnt_q == '0) err = ERR_START; else phase_d = PH_TOK3;
            end else if (cr || lf) err = ERR_START;
            else lcnt_d = 5'd1;
          end
          PH_TOK3: begin
            if (cr) phase_d = PH_START_LF;
            else if (lf) err = ERR_START;
          end
          PH_START_LF: begin
            if (lf) phase_d = PH_LINE; else err = ERR_START;
          end
          PH_LINE: begin
            if (cr) phase_d = PH_END_LF;
            else if (req_i.ows || b == CH_COLON || lf) err = ERR_FIELD;
            else begin
              kflg_d = {lc == cl_char(5'd0), lc == te_char(5'd0)};
              kpos_d = 5'd1;
              phase_d = PH_KEY;
            end
          end
          PH_KEY: begin
            if (b == CH_COLON) begin
              nf[0] = kflg_q[0] && (kpos_q == TE_LEN);
              nf[1] = kflg_q[1] && (kpos_q == CL_LEN);
              kflg_d = nf; tok_d = '0; acc_d = '0; phase_d = PH_VALUE;
            end else if (cr || lf) err = ERR_FIELD;
            else begin
              if (!(kpos_q < TE_LEN && lc == te_char(kpos_q))) kflg_d[0] = 1'b0;
              if (!(kpos_q < CL_LEN && lc == cl_char(kpos_q))) kflg_d[1] = 1'b0;
              if (kpos_q < 5'd31) kpos_d = kpos_q + 5'd1;
            end
          end
          PH_VALUE: begin
            if (cr) phase_d = PH_VALUE_LF;
            else if (lf) err = ERR_FIELD;
            else if (kflg_q[0]) begin
              s = tok_q[3:0]; f = tok_q[4];
              if (b == CH_COMMA) begin
                if (s == 4'd7 || s == 4'd8) f = 1'b1;
                s = 4'd0;
              end else if (req_i.ows) begin
                if (s >= 4'd1 && s <= 4'd6) s = 4'd15;
                else if (s == 4'd7) s = 4'd8;
              end else if (s < 4'd7 && lc == ck_char(s[2:0])) s = s + 4'd1;
              else s = 4'd15;
              tok_d = {f, s};
            end else if (kflg_q[1]) begin
              unique case (tok_q)
                5'd0: begin
                  if (req_i.dig_ok) begin
                    acc_d = LEN_BITS'(req_i.dig); tok_d = 5'd1;
                  end else if (!req_i.ows) tok_d = 5'd3;
                end
                5'd1: begin
                  if (req_i.dig_ok) begin
                    if (dec_ext[AW-1:LEN_BITS] != '0) tok_d = 5'd3;
                    else acc_d = dec_ext[LEN_BITS-1:0];
                  end else if (req_i.ows) tok_d = 5'd2;
                  else tok_d = 5'd3;
                end
                5'd2: if (!req_i.ows) tok_d = 5'd3;
                default: tok_d = 5'd3;
              endcase
            end
          end
          PH_VALUE_LF: begin
            if (!lf) err = ERR_FIELD;
            else begin
              if (kflg_q[0]) begin
                if (tok_q[4] || tok_q[3:0] == 4'd7 || tok_q[3:0] == 4'd8) begin
                  if (mode_q == MODE_LEN) err = ERR_TE_CL;
                  else mode_d = MODE_CHUNK;
                end
              end else if (kflg_q[1]) begin
                if (mode_q == MODE_CHUNK) err = ERR_TE_CL;
                else if (tok_q != 5'd1 && tok_q != 5'd2) err = ERR_BAD_LEN;
                else if (mode_q == MODE_LEN) begin
                  if (acc_q != slen_q) err = ERR_DUP_LEN;
                end else begin
                  mode_d = MODE_LEN; slen_d = acc_q;
                end
              end
              if (err == ERR_NONE) phase_d = PH_LINE;
            end
          end
          PH_END_LF: begin
            if (!lf) err = ERR_FIELD;
            else if (mode_q == MODE_LEN) begin
              if ({{(AW-LEN_BITS){1'b0}}, slen_q} > AW'(body_limit_i)) err = ERR_BODY_LONG;
              else begin
                ev = EV_HEAD_LEN; len = slen_q;
                if (slen_q == '0) phase_d = PH_SKIP;
                else begin
                  rem_d = slen_q; phase_d = PH_BODY;
                end
              end
            end else if (mode_q == MODE_CHUNK) begin
              ev = EV_HEAD_CK;
              phase_d = PH_CLINE; lcnt_d = '0; tok_d = '0; acc_d = '0;
            end else begin
              ev = EV_HEAD; phase_d = PH_SKIP;
            end
          end
          PH_BODY: begin
            role = ROLE_BODY;
            rem_d = rem_q - LEN_BITS'(1);
            if (rem_d == '0) begin
              ev = EV_MSG_END; phase_d = PH_SKIP;
            end
          end
          PH_CLINE: begin
            role = ROLE_FRAME;
            if (cr) begin
              if (lcnt_q == '0) err = ERR_CHUNK_LINE; else phase_d = PH_CLF;
            end else if (lf || lcnt_q >= CHUNK_LINE_MAX) err = ERR_CHUNK_LINE;
            else begin
              lcnt_d = lcnt_q + 5'd1;
              if (tok_q == '0) begin
                if (req_i.hex_ok) begin
                  if (acc_q[LEN_BITS-1 -: 4] != 4'd0) err = ERR_CHUNK_LONG;
                  else acc_d = hex_ext[LEN_BITS-1:0];
                end else if (b == CH_SEMI && lcnt_q != '0) tok_d = 5'd1;
                else err = ERR_CHUNK_LINE;
              end
            end
          end
          PH_CLF: begin
            role = ROLE_FRAME;
            if (!lf) err = ERR_CHUNK_LINE;
            else if ({{(AW-LEN_BITS){1'b0}}, acc_q} > AW'(body_limit_i)) err = ERR_CHUNK_LONG;
            else begin
              ev = EV_CSIZE; len = acc_q;
              if (acc_q == '0) begin
                phase_d = PH_TRAILER; hcnt_d = '0; last_d = '0;
              end else begin
                rem_d = acc_q; phase_d = PH_CDATA;
              end
            end
          end
          PH_CDATA: begin
            role = ROLE_BODY;
            rem_d = rem_q - LEN_BITS'(1);
            if (rem_d == '0) begin
              phase_d = PH_CCRLF; lcnt_d = '0;
            end
          end
          PH_CCRLF: begin
            role = ROLE_FRAME;
            if (lcnt_q == '0) begin
              if (cr) lcnt_d = 5'd1; else err = ERR_NO_CRLF;
            end else if (lf) begin
              ev = EV_CDONE;
              phase_d = PH_CLINE; lcnt_d = '0; tok_d = '0; acc_d = '0;
            end else err = ERR_NO_CRLF;
          end
          PH_TRAILER: begin
            role = ROLE_FRAME;
            if (hcnt_q >= head_limit_i) err = ERR_TRAIL_LONG;
            else begin
              hcnt_d = hcnt_q + 13'd1;
              if (lf && ((hcnt_d == 13'd2 && last_q[7:0] == CH_CR) ||
                         last_q == 24'h0D0A0D)) begin
                ev = EV_MSG_END; phase_d = PH_SKIP;
              end else last_d = {last_q[15:0], b};
            end
          end
          default: ;
        endcase
      end
      if (err == ERR_NONE && phase_d == PH_SKIP && phase_q != PH_SKIP) begin
        mode_d = MODE_NONE; hcnt_d = '0; last_d = '0; kpos_d = '0; kflg_d = 2'b11;
        tok_d = '0; acc_d = '0; slen_d = '0; rem_d = '0; lcnt_d = '0;
      end
      if (err != ERR_NONE) begin
        serr_d = err; role = ROLE_DROP; ev = EV_ERROR; len = '0;
      end
    end
  end

  assign wdata = {b, role, ev, clip(len)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SKIP; mode_q <= MODE_NONE; hcnt_q <= '0; last_q <= '0;
      kpos_q <= '0; kflg_q <= 2'b11; tok_q <= '0; acc_q <= '0; slen_q <= '0;
      rem_q <= '0; lcnt_q <= '0; serr_q <= ERR_NONE;
      cnt_q <= '0; rd_q <= 1'b0; wr_q <= 1'b0;
    end else begin
      if (fire) begin
        phase_q <= phase_d; mode_q <= mode_d; hcnt_q <= hcnt_d; last_q <= last_d;
        kpos_q <= kpos_d; kflg_q <= kflg_d; tok_q <= tok_d; acc_q <= acc_d;
        slen_q <= slen_d; rem_q <= rem_d; lcnt_q <= lcnt_d; serr_q <= serr_d;
        wr_q <= ~wr_q;
      end
      if (pop && !empty) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(fire) - 2'(pop && !empty);
    end
  end

  // error code rides with each entry
  logic [3:0] ecode_q [2];
  always_ff @(posedge clk_i) begin
    if (fire) begin
      mem_q[wr_q]   <= wdata;
      ecode_q[wr_q] <= serr_d;
    end
  end

  assign empty          = (cnt_q == 2'd0);
  assign out_byte_o     = mem_q[rd_q][44:37];
  assign byte_role_o    = mem_q[rd_q][36:35];
  assign event_res_o    = mem_q[rd_q][34:32];
  assign length_value_o = mem_q[rd_q][31:0];
  assign error_code_o   = ecode_q[rd_q];

endmodule
